>>> rtl/gunf_pkg.sv
// Shared types, constants and helper functions for the grid upper-neighbor finder.
package gunf_pkg;

    localparam int IDX_BITS      = 12;
    localparam int STORE_DEPTH   = 4096;
    localparam int OUT_VAL_BITS  = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int DIM_REG_BITS  = 5;
    localparam int MODE_BITS     = 2;
    localparam int K_BITS        = 5;

    localparam int MAX_DIM_DEF    = 16;
    localparam int VALUE_BITS_DEF = 32;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // config register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_Z     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NB_MODE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIND_MAX  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_THR   = 3'd6;

    // neighborhood modes
    localparam logic [MODE_BITS-1:0] MODE_SIX        = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_SIMPLICIAL = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FULL       = 2'd2;

    // config reset values
    localparam logic [DIM_REG_BITS-1:0] DIM_RST     = 5'd16;
    localparam logic [MODE_BITS-1:0]    MODE_RST    = MODE_SIMPLICIAL;
    localparam logic                    FIND_MAX_RST = 1'b1;

    localparam logic signed [1:0] OFF_P = 2'sd1;
    localparam logic signed [1:0] OFF_Z = 2'sd0;
    localparam logic signed [1:0] OFF_M = -2'sd1;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } t_off;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLANE,
        ST_CHECK,
        ST_DIV_Z,
        ST_DIV_Y,
        ST_WALK,
        ST_FINISH,
        ST_RESP
    } t_state;

    // fixed walk order: faces, simplicial diagonals, then the rest of the cube
    function automatic t_off nb_off(input logic [K_BITS-1:0] k);
        t_off o;
        unique case (k)
            5'd0:    o = '{OFF_P, OFF_Z, OFF_Z};
            5'd1:    o = '{OFF_M, OFF_Z, OFF_Z};
            5'd2:    o = '{OFF_Z, OFF_P, OFF_Z};
            5'd3:    o = '{OFF_Z, OFF_M, OFF_Z};
            5'd4:    o = '{OFF_Z, OFF_Z, OFF_P};
            5'd5:    o = '{OFF_Z, OFF_Z, OFF_M};
            5'd6:    o = '{OFF_P, OFF_P, OFF_Z};
            5'd7:    o = '{OFF_M, OFF_M, OFF_Z};
            5'd8:    o = '{OFF_Z, OFF_P, OFF_P};
            5'd9:    o = '{OFF_Z, OFF_M, OFF_M};
            5'd10:   o = '{OFF_P, OFF_Z, OFF_P};
            5'd11:   o = '{OFF_M, OFF_Z, OFF_M};
            5'd12:   o = '{OFF_P, OFF_P, OFF_P};
            5'd13:   o = '{OFF_M, OFF_M, OFF_M};
            5'd14:   o = '{OFF_P, OFF_M, OFF_Z};
            5'd15:   o = '{OFF_M, OFF_P, OFF_Z};
            5'd16:   o = '{OFF_Z, OFF_P, OFF_M};
            5'd17:   o = '{OFF_Z, OFF_M, OFF_P};
            5'd18:   o = '{OFF_P, OFF_Z, OFF_M};
            5'd19:   o = '{OFF_M, OFF_Z, OFF_P};
            5'd20:   o = '{OFF_P, OFF_P, OFF_M};
            5'd21:   o = '{OFF_P, OFF_M, OFF_P};
            5'd22:   o = '{OFF_M, OFF_P, OFF_P};
            5'd23:   o = '{OFF_P, OFF_M, OFF_M};
            5'd24:   o = '{OFF_M, OFF_P, OFF_M};
            5'd25:   o = '{OFF_M, OFF_M, OFF_P};
            default: o = '{OFF_Z, OFF_Z, OFF_Z};
        endcase
        return o;
    endfunction

    function automatic logic [K_BITS-1:0] nb_count(input logic [MODE_BITS-1:0] mode);
        logic [K_BITS-1:0] n;
        unique case (mode)
            MODE_SIMPLICIAL: n = 5'd14;
            MODE_FULL:       n = 5'd26;
            default:         n = 5'd6;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/gunf_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module gunf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while i_re is low
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/grid_upper_neighbor_finder.sv
// Top level: voxel store with 3D neighbor walk and (value, index) ordering filter.
//
// Write beat: one result beat after accept, through PLANE, CHECK and RESP (store written on the accept edge).
// Query beat: a bit-per-cycle divider splits the index into coordinates, then the walk
//   visits N = 6, 14 or 26 neighbors; the single store read port fetches one neighbor
//   per cycle while the walk does not stall.
// Output back-pressure adds stall cycles. One item is in flight at a time.
// Reset clears control state and loads the config defaults; the store is not cleared.
module grid_upper_neighbor_finder #(
    parameter int MAX_DIM    = gunf_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = gunf_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [gunf_pkg::IDX_BITS-1:0]       i_voxel_index,
    input  logic signed [gunf_pkg::OUT_VAL_BITS-1:0] i_voxel_value,
    input  logic                                i_want_smaller,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gunf_pkg::IDX_BITS-1:0]       o_neighbor_index,
    output logic signed [gunf_pkg::OUT_VAL_BITS-1:0] o_neighbor_value,
    output logic                                o_found,
    output logic                                o_bad_index,
    output logic                                o_last,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gunf_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gunf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    import gunf_pkg::*;

    // DIMW holds any effective dimension; coordinates and quotients fit in it too.
    localparam int DIMW = $clog2(MAX_DIM + 1);
    localparam int PW   = 2 * DIMW;
    localparam int SW   = $clog2(DIMW);
    localparam int IW   = IDX_BITS;
    // wide enough for the grid volume, shifted divisors and signed neighbor index
    localparam int WW   = ((3 * DIMW > IW) ? 3 * DIMW : IW) + 2;

    // ---------------------------------------------------------------- config
    logic [DIM_REG_BITS-1:0]  r_dim_x, r_dim_y, r_dim_z;
    logic [MODE_BITS-1:0]     r_nb_mode;
    logic signed [CFG_DATA_BITS-1:0] r_threshold;
    logic                     r_find_max;
    logic                     r_use_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x     <= DIM_RST;
            r_dim_y     <= DIM_RST;
            r_dim_z     <= DIM_RST;
            r_nb_mode   <= MODE_RST;
            r_threshold <= '0;
            r_find_max  <= FIND_MAX_RST;
            r_use_thr   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIM_X:     r_dim_x     <= i_cfg_data[DIM_REG_BITS-1:0];
                CFG_DIM_Y:     r_dim_y     <= i_cfg_data[DIM_REG_BITS-1:0];
                CFG_DIM_Z:     r_dim_z     <= i_cfg_data[DIM_REG_BITS-1:0];
                CFG_NB_MODE:   r_nb_mode   <= i_cfg_data[MODE_BITS-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_FIND_MAX:  r_find_max  <= i_cfg_data[0];
                CFG_USE_THR:   r_use_thr   <= i_cfg_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Effective dims: zero acts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIMW-1:0] clamp_dim(input logic [DIM_REG_BITS-1:0] d);
        logic [DIMW-1:0] r;
        if (d == '0) begin
            r = DIMW'(1);
        end else if (32'(d) > 32'(MAX_DIM)) begin
            r = DIMW'(MAX_DIM);
        end else begin
            r = DIMW'(d);
        end
        return r;
    endfunction

    logic [DIMW-1:0] eff_dx, eff_dy, eff_dz;
    assign eff_dx = clamp_dim(r_dim_x);
    assign eff_dy = clamp_dim(r_dim_y);
    assign eff_dz = clamp_dim(r_dim_z);

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    logic                  r_op;
    logic [IW-1:0]         r_idx;
    logic                  r_small;
    logic                  r_bad;
    logic [PW-1:0]         r_plane;

    // shared restoring divider: z = idx / plane, then y = rem / dim_x, x = rem % dim_x
    logic [IW-1:0]         r_rem;
    logic [DIMW-1:0]       r_quo;
    logic [SW-1:0]         r_step;
    logic [DIMW-1:0]       r_cx, r_cy, r_cz;
    logic signed [VALUE_BITS-1:0] r_cval;

    // walk: issue stage index and compare stage tag
    logic [K_BITS-1:0]     r_k;
    logic                  r_cmp_valid;
    logic [IW-1:0]         r_cmp_idx;

    // last qualifying neighbor, held until we know whether another follows
    logic                  r_pend_valid;
    logic [IW-1:0]         r_pend_idx;
    logic signed [VALUE_BITS-1:0] r_pend_val;

    // output register
    logic                  r_out_valid;
    logic [IW-1:0]         r_out_idx;
    logic signed [OUT_VAL_BITS-1:0] r_out_val;
    logic                  r_out_found;
    logic                  r_out_bad;
    logic                  r_out_last;

    logic in_beat;
    logic out_free;
    assign in_beat  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- store
    logic                  ram_we;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    assign ram_we = in_beat && (i_opcode == OP_WRITE);

    gunf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_voxel_index),
        .i_wdata (i_voxel_value[VALUE_BITS-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- datapath
    // range check: idx >= dx*dy*dz
    logic [WW-1:0] total_w;
    logic          bad_now;
    assign total_w = WW'(r_plane) * WW'(eff_dz);
    assign bad_now = WW'(r_idx) >= total_w;

    // one divider step
    logic [PW-1:0]   div_src;
    logic [WW-1:0]   trial;
    logic            div_ge;
    logic [IW-1:0]   rem_nxt;
    logic [DIMW-1:0] quo_nxt;

    assign div_src = (r_state == ST_DIV_Y) ? PW'(eff_dx) : r_plane;
    assign trial   = WW'(div_src) << r_step;
    assign div_ge  = WW'(r_rem) >= trial;
    assign rem_nxt = div_ge ? IW'(WW'(r_rem) - trial) : r_rem;
    assign quo_nxt = {r_quo[DIMW-2:0], div_ge};

    // neighbor address for walk index r_k
    t_off              off;
    logic [K_BITS-1:0] nb_n;
    logic              k_live;
    logic signed [DIMW+1:0] nxs, nys, nzs;
    logic              in_grid;
    logic signed [WW-1:0] dx_w, plane_w, nidx_s;
    logic              nb_ok;

    assign off    = nb_off(r_k);
    assign nb_n   = nb_count(r_nb_mode);
    assign k_live = r_k < nb_n;

    assign nxs = $signed({2'b00, r_cx}) + (DIMW+2)'(off.dx);
    assign nys = $signed({2'b00, r_cy}) + (DIMW+2)'(off.dy);
    assign nzs = $signed({2'b00, r_cz}) + (DIMW+2)'(off.dz);

    assign in_grid = !nxs[DIMW+1] && !nys[DIMW+1] && !nzs[DIMW+1]
                  && (nxs < $signed({2'b00, eff_dx}))
                  && (nys < $signed({2'b00, eff_dy}))
                  && (nzs < $signed({2'b00, eff_dz}));

    // linear index moves by +-1, +-dim_x and +-plane: adds only
    assign dx_w    = $signed(WW'(eff_dx));
    assign plane_w = $signed(WW'(r_plane));

    always_comb begin
        nidx_s = $signed(WW'(r_idx)) + WW'(off.dx);
        if (off.dy == OFF_P) begin
            nidx_s = nidx_s + dx_w;
        end else if (off.dy == OFF_M) begin
            nidx_s = nidx_s - dx_w;
        end
        if (off.dz == OFF_P) begin
            nidx_s = nidx_s + plane_w;
        end else if (off.dz == OFF_M) begin
            nidx_s = nidx_s - plane_w;
        end
    end

    // inside the grid is never negative; indexes past the store are skipped
    assign nb_ok = k_live && in_grid && (nidx_s[WW-1:IW] == '0);

    // compare stage on the value returned from the store
    logic signed [VALUE_BITS-1:0]   nval;
    logic signed [OUT_VAL_BITS-1:0] nval_w;
    logic thr_ok, above, qual, stall;

    assign nval   = $signed(ram_rdata);
    assign nval_w = OUT_VAL_BITS'(nval);
    assign thr_ok = !r_use_thr || (r_find_max ? (nval_w >= r_threshold)
                                              : (nval_w <= r_threshold));
    assign above  = (nval != r_cval) ? (nval > r_cval) : (r_cmp_idx > r_idx);
    assign qual   = r_cmp_valid && thr_ok && (above != r_small);
    // a new hit displaces the pending one, which needs a free output slot
    assign stall  = qual && r_pend_valid && !out_free;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) n_state = ST_PLANE;
            end
            ST_PLANE: n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_op == OP_WRITE || bad_now) n_state = ST_RESP;
                else                             n_state = ST_DIV_Z;
            end
            ST_DIV_Z: begin
                if (r_step == '0) n_state = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (r_step == '0) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!stall && !k_live) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    logic                           push;
    logic [IW-1:0]                  n_out_idx;
    logic signed [OUT_VAL_BITS-1:0] n_out_val;
    logic                           n_out_found;
    logic                           n_out_bad;
    logic                           n_out_last;

    always_comb begin
        o_in_ready  = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;
        push        = 1'b0;
        n_out_idx   = '0;
        n_out_val   = '0;
        n_out_found = 1'b0;
        n_out_bad   = 1'b0;
        n_out_last  = 1'b1;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_CHECK: begin
                // center value; it sits on the read port through the divide
                ram_re = (r_op == OP_QUERY);
            end
            ST_WALK: begin
                ram_re    = !stall && nb_ok;
                ram_raddr = nidx_s[IW-1:0];
                if (qual && r_pend_valid && out_free) begin
                    push        = 1'b1;
                    n_out_idx   = r_pend_idx;
                    n_out_val   = OUT_VAL_BITS'(r_pend_val);
                    n_out_found = 1'b1;
                    n_out_last  = 1'b0;
                end
            end
            ST_FINISH: begin
                push = out_free;
                if (r_pend_valid) begin
                    n_out_idx   = r_pend_idx;
                    n_out_val   = OUT_VAL_BITS'(r_pend_val);
                    n_out_found = 1'b1;
                end
            end
            ST_RESP: begin
                push      = out_free;
                n_out_bad = r_bad;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cmp_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_DIV_Y && r_step == '0) begin
                r_cmp_valid  <= 1'b0;
                r_pend_valid <= 1'b0;
            end else if (r_state == ST_WALK && !stall) begin
                r_cmp_valid <= nb_ok;
                if (qual) r_pend_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op    <= i_opcode;
            r_idx   <= i_voxel_index;
            r_small <= i_want_smaller;
        end

        if (r_state == ST_PLANE) begin
            r_plane <= PW'(eff_dx) * PW'(eff_dy);
        end

        if (r_state == ST_CHECK) begin
            r_bad  <= bad_now;
            r_rem  <= r_idx;
            r_quo  <= '0;
            r_step <= SW'(DIMW - 1);
        end

        if (r_state == ST_DIV_Z || r_state == ST_DIV_Y) begin
            r_rem  <= rem_nxt;
            r_quo  <= quo_nxt;
            r_step <= r_step - SW'(1);
            if (r_step == '0) begin
                r_quo  <= '0;
                r_step <= SW'(DIMW - 1);
                if (r_state == ST_DIV_Z) begin
                    r_cz <= quo_nxt;
                end else begin
                    r_cy   <= quo_nxt;
                    r_cx   <= DIMW'(rem_nxt);
                    r_cval <= nval;
                    r_k    <= '0;
                end
            end
        end

        if (r_state == ST_WALK && !stall) begin
            r_cmp_idx <= nidx_s[IW-1:0];
            if (k_live) r_k <= r_k + K_BITS'(1);
            if (qual) begin
                r_pend_idx <= r_cmp_idx;
                r_pend_val <= nval;
            end
        end

        if (push) begin
            r_out_idx   <= n_out_idx;
            r_out_val   <= n_out_val;
            r_out_found <= n_out_found;
            r_out_bad   <= n_out_bad;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_neighbor_index = r_out_idx;
    assign o_neighbor_value = r_out_val;
    assign o_found          = r_out_found;
    assign o_bad_index      = r_out_bad;
    assign o_last           = r_out_last;

endmodule
